// ===== rtl/gbdi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdi_pkg: shared definitions of the genotype decoder
// Field widths, header constants, result and error codes, the configuration
// record and the 2-bit genotype decode table.
// ----------------------------------------------------------------------------
package gbdi_pkg;

	// Default width of the sample and variant counters.
	localparam int COUNT_WIDTH_DEF = 24;

	// Fixed field widths of the ports.
	localparam int CFG_W       = 24;
	localparam int IDX_OUT_W   = 24;
	localparam int CFG_INDEX_W = 2;

	// Depth of the queue between the front and the back.
	localparam int FIFO_DEPTH = 2;

	// Header bytes of a SNP-major file.
	localparam logic [7:0] MAGIC_FIRST    = 8'h6c;
	localparam logic [7:0] MAGIC_SECOND   = 8'h1b;
	localparam logic [7:0] MODE_SNP_MAJOR = 8'h01;

	// Header position at which the header is complete.
	localparam logic [1:0] HDR_DONE = 2'd3;

	// Two-bit genotype codes.
	localparam logic [1:0] CODE_MASK    = 2'h3;
	localparam logic [1:0] CODE_MISSING = 2'd1;

	// Kind of a result word.
	typedef enum logic [1:0] {
		KIND_GENOTYPE = 2'd0,
		KIND_FILL     = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	// Error code of a result word.
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_MAGIC = 2'd1,
		ERR_MODE  = 2'd2
	} error_t;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SAMPLE_COUNT  = 2'd0,
		CFG_VARIANT_COUNT = 2'd1,
		CFG_IMPUTE_MODE   = 2'd2
	} cfg_index_t;

	// Configuration registers as seen by the front.
	typedef struct packed {
		logic [CFG_W-1:0] sample_count;
		logic [CFG_W-1:0] variant_count;
		logic [1:0]       impute_mode;
	} cfg_t;

	// Width of one queue entry for a given counter width.
	function automatic int entry_width(input int cw);
		return 16 + 2 * cw;
	endfunction

	// Dosage of a non-missing code: 0 gives 2, 2 gives 1, 3 gives 0.
	function automatic logic [1:0] decode_code(input logic [1:0] code);
		logic [1:0] v;
		unique case (code)
			2'd0:    v = 2'd2;
			2'd2:    v = 2'd1;
			default: v = 2'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/gbdi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdi_front: byte intake and classification
// Checks the header, tracks sample and variant position, turns each data byte
// within the variant count into one queue entry that tells the back what to emit.
// ----------------------------------------------------------------------------
module gbdi_front #(
	parameter int COUNT_WIDTH = gbdi_pkg::COUNT_WIDTH_DEF,
	parameter int ENTRY_W     = gbdi_pkg::entry_width(COUNT_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gbdi_pkg::cfg_t      cfg,
	input  logic                accept,
	input  logic [7:0]          bed_byte,
	output logic                push,
	output logic [ENTRY_W-1:0]  push_data
);

	localparam int CMP_W = (COUNT_WIDTH > gbdi_pkg::CFG_W) ? COUNT_WIDTH : gbdi_pkg::CFG_W;

	typedef struct packed {
		logic                   is_err;
		gbdi_pkg::error_t       err_code;
		logic [7:0]             codes;
		logic [2:0]             n_codes;
		logic                   var_end;
		logic                   fill_req;
		logic [COUNT_WIDTH-1:0] sidx;
		logic [COUNT_WIDTH-1:0] vidx;
	} entry_t;

	logic [1:0]             hdr_pos_q;
	logic                   magic_good_q;
	logic                   halted_q;
	logic [COUNT_WIDTH-1:0] sample_ctr_q;
	logic [COUNT_WIDTH-1:0] variant_ctr_q;

	logic [CMP_W-1:0]       sc_ext;
	logic [CMP_W-1:0]       vc_ext;
	logic [CMP_W-1:0]       sctr_ext;
	logic [CMP_W-1:0]       vctr_ext;
	logic [CMP_W-1:0]       new_ext;
	logic [CMP_W-1:0]       remaining;
	logic [2:0]             n_codes;
	logic [COUNT_WIDTH-1:0] new_ctr;
	logic                   var_end;
	logic                   in_header;
	logic                   past_end;
	logic                   hdr_fail;
	gbdi_pkg::error_t       hdr_err;
	entry_t                 entry;

	// Position arithmetic for one data byte.
	always_comb begin
		sc_ext    = CMP_W'(cfg.sample_count);
		vc_ext    = CMP_W'(cfg.variant_count);
		sctr_ext  = CMP_W'(sample_ctr_q);
		vctr_ext  = CMP_W'(variant_ctr_q);
		remaining = (sctr_ext < sc_ext) ? (sc_ext - sctr_ext) : '0;
		n_codes   = (remaining >= CMP_W'(4)) ? 3'd4 : remaining[2:0];
		new_ctr   = COUNT_WIDTH'(sample_ctr_q + COUNT_WIDTH'(n_codes));
		new_ext   = CMP_W'(new_ctr);
		var_end   = (new_ext >= sc_ext);
		in_header = (hdr_pos_q != gbdi_pkg::HDR_DONE);
		past_end  = (vctr_ext >= vc_ext);
	end

	// Header check at the mode byte; a bad magic takes precedence.
	always_comb begin
		hdr_fail = 1'b0;
		hdr_err  = gbdi_pkg::ERR_NONE;
		if (hdr_pos_q == 2'd2) begin
			if (!magic_good_q) begin
				hdr_fail = 1'b1;
				hdr_err  = gbdi_pkg::ERR_MAGIC;
			end else if (bed_byte != gbdi_pkg::MODE_SNP_MAJOR) begin
				hdr_fail = 1'b1;
				hdr_err  = gbdi_pkg::ERR_MODE;
			end
		end
	end

	// Queue entry for the current byte.
	always_comb begin
		entry.is_err   = in_header;
		entry.err_code = hdr_err;
		entry.codes    = bed_byte;
		entry.n_codes  = n_codes;
		entry.var_end  = var_end;
		entry.fill_req = var_end && (cfg.impute_mode != 2'd0);
		entry.sidx     = sample_ctr_q;
		entry.vidx     = variant_ctr_q;
		if (in_header) begin
			entry.n_codes  = 3'd0;
			entry.var_end  = 1'b0;
			entry.fill_req = 1'b0;
			entry.sidx     = '0;
			entry.vidx     = '0;
		end
		push_data = entry;
		push      = accept && !halted_q && (in_header ? hdr_fail : !past_end);
	end

	// Header and position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q     <= '0;
			magic_good_q  <= 1'b1;
			halted_q      <= 1'b0;
			sample_ctr_q  <= '0;
			variant_ctr_q <= '0;
		end else if (accept && !halted_q) begin
			if (in_header) begin
				if (hdr_pos_q == 2'd0 && bed_byte != gbdi_pkg::MAGIC_FIRST) begin
					magic_good_q <= 1'b0;
				end
				if (hdr_pos_q == 2'd1 && bed_byte != gbdi_pkg::MAGIC_SECOND) begin
					magic_good_q <= 1'b0;
				end
				if (hdr_fail) begin
					halted_q <= 1'b1;
				end else begin
					hdr_pos_q <= hdr_pos_q + 2'd1;
				end
			end else if (!past_end) begin
				if (var_end) begin
					sample_ctr_q  <= '0;
					variant_ctr_q <= variant_ctr_q + COUNT_WIDTH'(1);
				end else begin
					sample_ctr_q <= new_ctr;
				end
			end
		end
	end

endmodule

// ===== rtl/gbdi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdi_fifo: short queue between front and back
// A small register queue; the head is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module gbdi_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = gbdi_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/gbdi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdi_back: result generation
// Walks one queue entry's codes, one result word per cycle unless stalled, keeps
// the per-variant dosage sum and count and emits the rounded fill value.
// ----------------------------------------------------------------------------
module gbdi_back #(
	parameter int COUNT_WIDTH = gbdi_pkg::COUNT_WIDTH_DEF,
	parameter int ENTRY_W     = gbdi_pkg::entry_width(COUNT_WIDTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  logic [ENTRY_W-1:0]                head_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        kind,
	output logic [gbdi_pkg::IDX_OUT_W-1:0]    sample_index,
	output logic [gbdi_pkg::IDX_OUT_W-1:0]    variant_index,
	output logic [1:0]                        genotype,
	output logic                              missing,
	output logic                              fill_valid,
	output logic [1:0]                        error_code,
	output logic                              last
);

	localparam int CMP_W = (COUNT_WIDTH > gbdi_pkg::IDX_OUT_W) ? COUNT_WIDTH
	                                                          : gbdi_pkg::IDX_OUT_W;

	typedef struct packed {
		logic                   is_err;
		gbdi_pkg::error_t       err_code;
		logic [7:0]             codes;
		logic [2:0]             n_codes;
		logic                   var_end;
		logic                   fill_req;
		logic [COUNT_WIDTH-1:0] sidx;
		logic [COUNT_WIDTH-1:0] vidx;
	} entry_t;

	entry_t                 entry_q;
	logic                   busy_q;
	logic [2:0]             step_q;
	logic [COUNT_WIDTH:0]   sum_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   out_valid_q;

	logic                   out_free;
	logic                   fire;
	logic                   emit;
	logic                   done;
	logic                   acc;
	logic [1:0]             code;
	logic [1:0]             dosage;
	logic [COUNT_WIDTH+1:0] two_sum;
	logic [COUNT_WIDTH+1:0] three_cnt;
	logic [1:0]             fill_val;
	logic [COUNT_WIDTH-1:0] cur_sidx;
	logic [CMP_W-1:0]       sidx_ext;
	logic [CMP_W-1:0]       vidx_ext;
	gbdi_pkg::kind_t        r_kind;
	logic [1:0]             r_geno;
	logic                   r_miss;
	logic                   r_fvalid;
	logic                   r_last;
	logic [CMP_W-1:0]       r_sidx;
	logic [CMP_W-1:0]       r_vidx;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = busy_q && out_free;
	assign pop      = head_valid && (!busy_q || (fire && done));

	// Rounded mean as compares: the fill is at least 1 when 2s >= c and 2 when 2s >= 3c.
	always_comb begin
		two_sum   = {sum_q, 1'b0};
		three_cnt = (COUNT_WIDTH + 2)'(cnt_q) + {1'b0, cnt_q, 1'b0};
		if (two_sum >= three_cnt) begin
			fill_val = 2'd2;
		end else if (two_sum >= (COUNT_WIDTH + 2)'(cnt_q)) begin
			fill_val = 2'd1;
		end else begin
			fill_val = 2'd0;
		end
	end

	// Step selection for the current entry.
	always_comb begin
		code     = 2'(entry_q.codes >> {step_q[1:0], 1'b0}) & gbdi_pkg::CODE_MASK;
		dosage   = gbdi_pkg::decode_code(code);
		cur_sidx = COUNT_WIDTH'(entry_q.sidx + COUNT_WIDTH'(step_q[1:0]));
		sidx_ext = CMP_W'(cur_sidx);
		vidx_ext = CMP_W'(entry_q.vidx);
		emit     = 1'b0;
		done     = 1'b0;
		acc      = 1'b0;
		r_kind   = gbdi_pkg::KIND_GENOTYPE;
		r_geno   = 2'd0;
		r_miss   = 1'b0;
		r_fvalid = 1'b0;
		r_last   = 1'b0;
		r_sidx   = '0;
		r_vidx   = '0;
		if (entry_q.is_err) begin
			emit   = 1'b1;
			done   = 1'b1;
			r_kind = gbdi_pkg::KIND_ERROR;
			r_last = 1'b1;
		end else if (step_q < entry_q.n_codes) begin
			emit   = 1'b1;
			done   = (step_q == entry_q.n_codes - 3'd1) && !entry_q.fill_req;
			r_last = done;
			r_sidx = sidx_ext;
			r_vidx = vidx_ext;
			if (code == gbdi_pkg::CODE_MISSING) begin
				r_miss = 1'b1;
			end else begin
				r_geno = dosage;
				acc    = 1'b1;
			end
		end else if (entry_q.fill_req) begin
			emit     = 1'b1;
			done     = 1'b1;
			r_kind   = gbdi_pkg::KIND_FILL;
			r_last   = 1'b1;
			r_vidx   = vidx_ext;
			r_fvalid = (cnt_q != '0);
			r_geno   = (cnt_q != '0) ? fill_val : 2'd0;
		end else begin
			done = 1'b1;
		end
	end

	// Entry sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (fire && done) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head_data;
		end
	end

	// Per-variant dosage sum and count of non-missing codes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (fire && done && entry_q.var_end) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (fire && acc) begin
			sum_q <= sum_q + (COUNT_WIDTH + 1)'(dosage);
			cnt_q <= cnt_q + COUNT_WIDTH'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind          <= r_kind;
			sample_index  <= r_sidx[gbdi_pkg::IDX_OUT_W-1:0];
			variant_index <= r_vidx[gbdi_pkg::IDX_OUT_W-1:0];
			genotype      <= r_geno;
			missing       <= r_miss;
			fill_valid    <= r_fvalid;
			error_code    <= entry_q.is_err ? entry_q.err_code : gbdi_pkg::ERR_NONE;
			last          <= r_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/genotype_bed_decode_impute_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_bed_decode_impute_top: SNP-major genotype byte decoder
// Header check, 2-bit genotype unpacking and per-variant mean fill value.
// ----------------------------------------------------------------------------
// Feed the file one byte per word on the input channel, header first. A good
// header gives no results; a bad one gives a single error word and the block
// ignores all further bytes until reset. Each data byte within the variant count
// gives one genotype word per valid sample in it and, at the end of a variant
// with imputation on, a fill word; the final word of each byte carries last.
// The front takes one byte per cycle into a two-entry queue while it has room;
// the back emits one result word per cycle while the output is not stalled and
// keeps a data byte until it has sent its genotype words and any fill word.
// Write the configuration only while the block is idle.
module genotype_bed_decode_impute_top #(
	parameter int COUNT_WIDTH = gbdi_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gbdi_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gbdi_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          bed_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          kind,
	output logic [gbdi_pkg::IDX_OUT_W-1:0]      sample_index,
	output logic [gbdi_pkg::IDX_OUT_W-1:0]      variant_index,
	output logic [1:0]                          genotype,
	output logic                                missing,
	output logic                                fill_valid,
	output logic [1:0]                          error_code,
	output logic                                last
);

	localparam int ENTRY_W = gbdi_pkg::entry_width(COUNT_WIDTH);

	gbdi_pkg::cfg_t     cfg_q;
	logic               accept;
	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic               full;
	logic               head_valid;
	logic [ENTRY_W-1:0] head_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count  <= gbdi_pkg::CFG_W'(1);
			cfg_q.variant_count <= gbdi_pkg::CFG_W'(1);
			cfg_q.impute_mode   <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbdi_pkg::CFG_SAMPLE_COUNT:  cfg_q.sample_count  <= cfg_data;
				gbdi_pkg::CFG_VARIANT_COUNT: cfg_q.variant_count <= cfg_data;
				gbdi_pkg::CFG_IMPUTE_MODE:   cfg_q.impute_mode   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// A byte is taken whenever the queue has room.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	gbdi_front #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.bed_byte  (bed_byte),
		.push      (push),
		.push_data (push_data)
	);

	gbdi_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (gbdi_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	gbdi_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_data     (head_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.sample_index  (sample_index),
		.variant_index (variant_index),
		.genotype      (genotype),
		.missing       (missing),
		.fill_valid    (fill_valid),
		.error_code    (error_code),
		.last          (last)
	);

	// An error word always closes its byte and carries a nonzero code.
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == gbdi_pkg::KIND_ERROR |-> last && error_code != gbdi_pkg::ERR_NONE)
		else $error("error word without last or code");

	// A fill word is the last word of its byte and has no sample position.
	a_fill_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == gbdi_pkg::KIND_FILL |-> last && sample_index == '0 && !missing)
		else $error("malformed fill word");

	// Missing genotypes carry dosage zero, and no dosage exceeds two.
	a_dosage_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> genotype != 2'd3 && !(missing && genotype != 2'd0))
		else $error("genotype out of range");

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

endmodule

// ===== tb/genotype_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_decode_checker: result checker of the genotype byte decoder
// Follows register writes and accepted bytes, predicts the result words that
// each byte causes and compares every accepted result word, field by field,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module genotype_decode_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gbdi_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gbdi_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [7:0]                          bed_byte,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [1:0]                          kind,
	input  logic [gbdi_pkg::IDX_OUT_W-1:0]      sample_index,
	input  logic [gbdi_pkg::IDX_OUT_W-1:0]      variant_index,
	input  logic [1:0]                          genotype,
	input  logic                                missing,
	input  logic                                fill_valid,
	input  logic [1:0]                          error_code,
	input  logic                                last,
	output int                                  fail_count,
	output int                                  pending
);

	import gbdi_pkg::*;

	// Non-missing genotype codes and the imputation switch.
	localparam logic [1:0] CODE_HOM_FIRST = 2'd0;
	localparam logic [1:0] CODE_HET       = 2'd2;
	localparam logic [1:0] IMPUTE_OFF     = 2'd0;

	typedef struct packed {
		kind_t                kind;
		logic [IDX_OUT_W-1:0] sample_index;
		logic [IDX_OUT_W-1:0] variant_index;
		logic [1:0]           genotype;
		logic                 missing;
		logic                 fill_valid;
		error_t               error_code;
		logic                 last;
	} result_word_t;

	// Register copies.
	logic [CFG_W-1:0] cfg_samples;
	logic [CFG_W-1:0] cfg_variants;
	logic [1:0]       cfg_impute;

	// Decoder state.
	logic [1:0]           hdr_pos;
	logic                 magic_ok;
	logic                 halted;
	logic [IDX_OUT_W-1:0] sample_ctr;
	logic [IDX_OUT_W-1:0] variant_ctr;
	logic [IDX_OUT_W:0]   dosage_sum;
	logic [IDX_OUT_W-1:0] present_cnt;

	result_word_t expected_words[$];
	int           word_count;

	function automatic result_word_t make_word(input kind_t k,
			input logic [IDX_OUT_W-1:0] si, input logic [IDX_OUT_W-1:0] vi,
			input logic [1:0] g, input logic m, input logic fv, input error_t e);
		result_word_t w;
		w.kind          = k;
		w.sample_index  = si;
		w.variant_index = vi;
		w.genotype      = g;
		w.missing       = m;
		w.fill_valid    = fv;
		w.error_code    = e;
		w.last          = 1'b0;
		return w;
	endfunction

	function automatic string describe_word(input result_word_t w);
		return $sformatf({"kind %0d sample %0d variant %0d genotype %0d missing %0b",
			" fill_valid %0b error %0d last %0b"},
			w.kind, w.sample_index, w.variant_index, w.genotype, w.missing,
			w.fill_valid, w.error_code, w.last);
	endfunction

	// Work out the result words of one accepted byte and queue them.
	task automatic decode_byte(input logic [7:0] b);
		result_word_t    words[5];
		int              n;
		logic [1:0]      code;
		logic [1:0]      dosage;
		longint unsigned num;
		longint unsigned den;
		longint unsigned fill;
		n = 0;
		if (halted) begin
			return;
		end
		if (hdr_pos != HDR_DONE) begin
			// Header: magic pair, then the mode byte where any error shows.
			if (hdr_pos == 2'd0 && b != MAGIC_FIRST) begin
				magic_ok = 1'b0;
			end
			if (hdr_pos == 2'd1 && b != MAGIC_SECOND) begin
				magic_ok = 1'b0;
			end
			if (hdr_pos == 2'd2 && !magic_ok) begin
				words[0] = make_word(KIND_ERROR, '0, '0, 2'd0, 1'b0, 1'b0, ERR_MAGIC);
				n = 1;
				halted = 1'b1;
			end else if (hdr_pos == 2'd2 && b != MODE_SNP_MAJOR) begin
				words[0] = make_word(KIND_ERROR, '0, '0, 2'd0, 1'b0, 1'b0, ERR_MODE);
				n = 1;
				halted = 1'b1;
			end else begin
				hdr_pos = hdr_pos + 2'd1;
			end
		end else if (variant_ctr < cfg_variants) begin
			// Unpack up to four samples, least significant pair first.
			for (int k = 0; k < 4; k++) begin
				code = b[2*k +: 2];
				if (sample_ctr >= cfg_samples) begin
					break;
				end
				if (code == CODE_MISSING) begin
					words[n] = make_word(KIND_GENOTYPE, sample_ctr, variant_ctr, 2'd0,
						1'b1, 1'b0, ERR_NONE);
				end else begin
					case (code)
						CODE_HOM_FIRST: dosage = 2'd2;
						CODE_HET:       dosage = 2'd1;
						default:        dosage = 2'd0;
					endcase
					words[n] = make_word(KIND_GENOTYPE, sample_ctr, variant_ctr, dosage,
						1'b0, 1'b0, ERR_NONE);
					dosage_sum  = dosage_sum + dosage;
					present_cnt = present_cnt + 1'b1;
				end
				n++;
				sample_ctr = sample_ctr + 1'b1;
			end
			// End of variant: optional fill word, then clear the running sums.
			if (sample_ctr >= cfg_samples) begin
				if (cfg_impute != IMPUTE_OFF) begin
					if (present_cnt != 0) begin
						num  = 2 * longint'(dosage_sum) + longint'(present_cnt);
						den  = 2 * longint'(present_cnt);
						fill = num / den;
						if (fill > 2) begin
							fill = 2;
						end
						words[n] = make_word(KIND_FILL, '0, variant_ctr, fill[1:0], 1'b0,
							1'b1, ERR_NONE);
					end else begin
						words[n] = make_word(KIND_FILL, '0, variant_ctr, 2'd0, 1'b0,
							1'b0, ERR_NONE);
					end
					n++;
				end
				sample_ctr  = '0;
				dosage_sum  = '0;
				present_cnt = '0;
				variant_ctr = variant_ctr + 1'b1;
			end
		end
		for (int i = 0; i < n; i++) begin
			words[i].last = (i == n - 1);
			expected_words.push_back(words[i]);
		end
	endtask

	// Register writes, accepted bytes and accepted result words, in that order.
	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		result_word_t got;
		if (!arst_n) begin
			cfg_samples  = 24'd1;
			cfg_variants = 24'd1;
			cfg_impute   = IMPUTE_OFF;
			hdr_pos      = 2'd0;
			magic_ok     = 1'b1;
			halted       = 1'b0;
			sample_ctr   = '0;
			variant_ctr  = '0;
			dosage_sum   = '0;
			present_cnt  = '0;
			expected_words.delete();
			word_count   = 0;
			fail_count   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_COUNT:  cfg_samples  = cfg_data;
					CFG_VARIANT_COUNT: cfg_variants = cfg_data;
					CFG_IMPUTE_MODE:   cfg_impute   = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				decode_byte(bed_byte);
			end
			if (out_valid && !out_stall) begin
				got = {kind, sample_index, variant_index, genotype, missing, fill_valid,
					error_code, last};
				if (expected_words.size() == 0) begin
					if (fail_count < 10) begin
						$display("word %0d arrived with none expected: %s", word_count,
							describe_word(got));
					end
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display("word %0d mismatch", word_count);
							$display("  expected %s", describe_word(want));
							$display("  actual   %s", describe_word(got));
						end
						fail_count++;
					end
				end
				word_count++;
			end
		end
		pending = expected_words.size();
	end

endmodule

// ===== tb/genotype_bed_decode_impute_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_bed_decode_impute_top_test: regression of the genotype decoder
// Feeds a good header, a directed set of data bytes under several register
// settings and then random bytes in random register phases, with random
// idling on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module genotype_bed_decode_impute_top_test;

	import gbdi_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          SETTLE_CYCLES = 12;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_SAMPLE_COUNT;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic [7:0]             bed_byte = 8'h00;
	logic                   out_stall = 1'b0;

	logic                 in_stall;
	logic                 out_valid;
	logic [1:0]           kind;
	logic [IDX_OUT_W-1:0] sample_index;
	logic [IDX_OUT_W-1:0] variant_index;
	logic [1:0]           genotype;
	logic                 missing;
	logic                 fill_valid;
	logic [1:0]           error_code;
	logic                 last;

	int          fail_count;
	int          pending;
	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;
	bit          hold_pending = 1'b0;

	genotype_bed_decode_impute_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bed_byte      (bed_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.sample_index  (sample_index),
		.variant_index (variant_index),
		.genotype      (genotype),
		.missing       (missing),
		.fill_valid    (fill_valid),
		.error_code    (error_code),
		.last          (last)
	);

	genotype_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bed_byte      (bed_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.sample_index  (sample_index),
		.variant_index (variant_index),
		.genotype      (genotype),
		.missing       (missing),
		.fill_valid    (fill_valid),
		.error_code    (error_code),
		.last          (last),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("genotype_bed_decode_impute_top regression: fail");
			$finish;
		end
	end

	// Result side: short random stall bursts, plus one long hold on request.
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = 48;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one byte, maybe after a short gap, and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		bed_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Stop offering, wait for every predicted word, then let bytes that cause
	// no word drain out of the block.
	task automatic settle();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Good header, then one sample and one variant as after reset; the
		// second data byte lies past the last variant.
		send_byte(MAGIC_FIRST);
		send_byte(MAGIC_SECOND);
		send_byte(MODE_SNP_MAJOR);
		send_byte(8'hFF);
		send_byte(8'h00);

		// Raising the variant count resumes decoding; full bytes with fill.
		settle();
		write_reg(CFG_VARIANT_COUNT, 24'hFFFFFF);
		write_reg(CFG_SAMPLE_COUNT, 24'd4);
		write_reg(CFG_IMPUTE_MODE, 24'd1);
		send_byte(8'h00);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'hFF);
		send_byte(8'hE4);
		send_byte(8'h1B);

		// No samples with mode three: each byte ends a variant with no value.
		settle();
		write_reg(CFG_SAMPLE_COUNT, 24'd0);
		write_reg(CFG_IMPUTE_MODE, 24'd3);
		send_byte(8'h39);
		send_byte(8'hC6);

		// Sample count lowered in the middle of a variant.
		settle();
		write_reg(CFG_SAMPLE_COUNT, 24'd6);
		write_reg(CFG_IMPUTE_MODE, 24'd2);
		send_byte(8'h4E);
		settle();
		write_reg(CFG_SAMPLE_COUNT, 24'd3);
		send_byte(8'hB1);

		// Largest sample count, no imputation; then a lowered count ends the
		// variant with no word at all.
		settle();
		write_reg(CFG_SAMPLE_COUNT, 24'hFFFFFF);
		write_reg(CFG_IMPUTE_MODE, 24'd0);
		send_byte(8'h72);
		send_byte(8'h8D);
		settle();
		write_reg(CFG_SAMPLE_COUNT, 5);
		send_byte(8'h27);

		// Variant count zero: every byte is ignored.
		settle();
		write_reg(CFG_VARIANT_COUNT, 24'd0);
		send_byte(8'hFF);
		send_byte(8'h00);

		// Random phases; one holds off the result side for a long stretch and
		// the last runs without idling.
		for (int phase = 0; phase < 9; phase++) begin
			settle();
			r = $urandom_range(0, 9);
			write_reg(CFG_SAMPLE_COUNT, (r == 0) ? 24'd0 :
				(r == 1) ? 24'hFFFFFF : 24'($urandom_range(1, 9)));
			write_reg(CFG_VARIANT_COUNT, ($urandom_range(0, 7) == 0) ?
				24'($urandom_range(0, 40)) : 24'hFFFFFF);
			write_reg(CFG_IMPUTE_MODE, 24'($urandom_range(0, 3)));
			if (phase == 3) begin
				// Every byte gives words here, so the held result side fills the block.
				write_reg(CFG_SAMPLE_COUNT, 24'd8);
				write_reg(CFG_VARIANT_COUNT, 24'hFFFFFF);
				hold_pending = 1'b1;
			end
			if (phase == 8) begin
				quiet = 1'b1;
			end
			repeat (17) send_byte(8'($urandom_range(0, 255)));
		end
		settle();

		if (fail_count == 0 && pending == 0) begin
			$display("genotype_bed_decode_impute_top regression: pass");
		end else begin
			$display("genotype_bed_decode_impute_top regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gbdi_pkg.sv
rtl/gbdi_front.sv
rtl/gbdi_fifo.sv
rtl/gbdi_back.sv
rtl/genotype_bed_decode_impute_top.sv
tb/genotype_decode_checker.sv
tb/genotype_bed_decode_impute_top_test.sv
